### rtl/pavt_pkg.sv
// Package for the peak angular velocity tracker.
// Holds the shared widths, the Q3.13 constants, the arctangent table and the
// controller state, command and status types. No dependencies.
`default_nettype none

package pavt_pkg;

    localparam int IN_W         = 16;   // coordinate port width
    localparam int TIME_W       = 32;
    localparam int RATE_W       = 32;
    localparam int ANGLE_W      = 16;   // Q3.13 angle
    localparam int PHASE_W      = 18;   // angle sums and differences
    localparam int DIVN_W       = 18;   // |delta| << 3 fits here
    localparam int STEP_CNT_W   = 5;
    localparam int MAX_STEPS    = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_COORD_BITS   = 16;

    localparam logic signed [PHASE_W-1:0] PI_Q13     = 18'sd25736;
    localparam logic signed [PHASE_W-1:0] TWO_PI_Q13 = 18'sd51472;

    // Rounded Q3.13 arctangent of 2^-i
    function automatic logic [PHASE_W-1:0] atan_q13(input logic [STEP_CNT_W-1:0] i);
        logic [PHASE_W-1:0] v;
        case (i)
            5'd0:    v = 18'd6434;
            5'd1:    v = 18'd3798;
            5'd2:    v = 18'd2007;
            5'd3:    v = 18'd1019;
            5'd4:    v = 18'd511;
            5'd5:    v = 18'd256;
            5'd6:    v = 18'd128;
            5'd7:    v = 18'd64;
            5'd8:    v = 18'd32;
            5'd9:    v = 18'd16;
            5'd10:   v = 18'd8;
            5'd11:   v = 18'd4;
            5'd12:   v = 18'd2;
            5'd13:   v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ANGLE,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } pavt_state_t;

    typedef struct packed {
        logic load;
        logic cordic_step;
        logic angle;
        logic div_step;
        logic commit;
        logic emit;
    } pavt_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic div_done;
        logic need_div;
        logic last;
        logic out_busy;
    } pavt_sts_t;

endpackage

`default_nettype wire

### rtl/pavt_ctrl.sv
// Controller state machine for the peak angular velocity tracker.
// Depends on pavt_pkg; drives the datapath through pavt_cmd_t.
`default_nettype none

module pavt_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  pavt_pkg::pavt_sts_t sts,
    output pavt_pkg::pavt_cmd_t cmd
);
    import pavt_pkg::*;

    pavt_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (sts.cordic_done) begin
                    state_next = ST_ANGLE;
                end else begin
                    cmd.cordic_step = 1'b1;
                end
            end
            ST_ANGLE: begin
                cmd.angle  = 1'b1;
                state_next = sts.need_div ? ST_DIV : ST_UPDATE;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_UPDATE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_UPDATE: begin
                cmd.commit = 1'b1;
                state_next = sts.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/pavt_dp.sv
// Datapath for the peak angular velocity tracker: iterative CORDIC,
// angle wrap, restoring divider, run state and output register.
// Depends on pavt_pkg; commanded by pavt_ctrl.
`default_nettype none

module pavt_dp #(
    parameter int CORDIC_STEPS = pavt_pkg::DEF_CORDIC_STEPS,
    parameter int COORD_BITS   = pavt_pkg::DEF_COORD_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  signed [pavt_pkg::IN_W-1:0] s_x_coord,
    input  wire  signed [pavt_pkg::IN_W-1:0] s_y_coord,
    input  wire  [pavt_pkg::TIME_W-1:0]      s_time_stamp,
    input  wire                              s_last_point,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [pavt_pkg::RATE_W-1:0]      m_peak_rate,
    input  pavt_pkg::pavt_cmd_t              cmd,
    output pavt_pkg::pavt_sts_t              sts
);
    import pavt_pkg::*;

    localparam int DW    = COORD_BITS + 3;
    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    // Coordinate extension
    logic signed [DW-1:0] x_ext, y_ext;
    generate
        if (COORD_BITS <= IN_W) begin : g_sext
            assign x_ext = DW'(signed'(s_x_coord[COORD_BITS-1:0]));
            assign y_ext = DW'(signed'(s_y_coord[COORD_BITS-1:0]));
        end else begin : g_zext
            assign x_ext = DW'(signed'({1'b0, s_x_coord}));
            assign y_ext = DW'(signed'({1'b0, s_y_coord}));
        end
    endgenerate

    logic signed [DW-1:0]      cx_reg, cy_reg;
    logic signed [PHASE_W-1:0] z_reg;
    logic [STEP_CNT_W-1:0]     step_reg;
    logic                      special_reg;
    logic signed [PHASE_W-1:0] special_angle_reg;
    logic [TIME_W-1:0]         t_reg;
    logic                      last_reg;

    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [ANGLE_W-1:0] prev_angle_reg;
    logic [TIME_W-1:0]         prev_time_reg;
    logic                      have_prev_reg;
    logic [RATE_W-1:0]         peak_reg;

    logic [DIVN_W-1:0]         n_reg;
    logic [TIME_W-1:0]         rem_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic [DIVN_W-1:0]         q_reg;
    logic [STEP_CNT_W-1:0]     div_cnt_reg;

    logic                      m_valid_reg;
    logic [RATE_W-1:0]         m_peak_reg;

    // CORDIC micro-rotation
    logic signed [DW-1:0]      xs, ys;
    logic [PHASE_W-1:0]        atan_v;
    assign xs     = cx_reg >>> step_reg;
    assign ys     = cy_reg >>> step_reg;
    assign atan_v = atan_q13(step_reg);

    // Clamp, delta and wrap
    logic signed [PHASE_W-1:0] z_cl, d_raw, d_wr;
    logic [PHASE_W-1:0]        mag;
    always_comb begin
        if (special_reg) begin
            z_cl = special_angle_reg;
        end else if (z_reg > PI_Q13) begin
            z_cl = PI_Q13;
        end else if (z_reg < -PI_Q13) begin
            z_cl = -PI_Q13;
        end else begin
            z_cl = z_reg;
        end
        d_raw = z_cl - PHASE_W'(prev_angle_reg);
        if (d_raw > PI_Q13) begin
            d_wr = d_raw - TWO_PI_Q13;
        end else if (d_raw < -PI_Q13) begin
            d_wr = d_raw + TWO_PI_Q13;
        end else begin
            d_wr = d_raw;
        end
        mag = d_wr[PHASE_W-1] ? PHASE_W'(-d_wr) : PHASE_W'(d_wr);
    end

    // Restoring divider step
    logic [TIME_W:0] rem_sh;
    logic            rem_ge;
    assign rem_sh = {rem_reg, n_reg[DIVN_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dt_reg};

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            step_reg    <= '0;
            t_reg       <= s_time_stamp;
            last_reg    <= s_last_point;
            special_reg <= (y_ext == '0);
            special_angle_reg <= x_ext[DW-1] ? PI_Q13 : '0;
            if (x_ext[DW-1]) begin
                cx_reg <= -x_ext;
                cy_reg <= -y_ext;
                z_reg  <= y_ext[DW-1] ? -PI_Q13 : PI_Q13;
            end else begin
                cx_reg <= x_ext;
                cy_reg <= y_ext;
                z_reg  <= '0;
            end
        end else if (cmd.cordic_step) begin
            step_reg <= step_reg + 1'b1;
            if (!cy_reg[DW-1]) begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                z_reg  <= z_reg + signed'(atan_v);
            end else begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                z_reg  <= z_reg - signed'(atan_v);
            end
        end
        if (cmd.angle) begin
            angle_reg   <= ANGLE_W'(z_cl);
            n_reg       <= mag << 3;
            rem_reg     <= '0;
            q_reg       <= '0;
            dt_reg      <= t_reg - prev_time_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            n_reg       <= n_reg << 1;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            q_reg       <= {q_reg[DIVN_W-2:0], rem_ge};
            rem_reg     <= rem_ge ? TIME_W'(rem_sh - {1'b0, dt_reg})
                                  : rem_sh[TIME_W-1:0];
        end
    end

    // Run state and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            prev_time_reg  <= '0;
            have_prev_reg  <= 1'b0;
            peak_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.commit) begin
                if (sts.need_div && (RATE_W'(q_reg) > peak_reg)) begin
                    peak_reg <= RATE_W'(q_reg);
                end
                prev_angle_reg <= angle_reg;
                prev_time_reg  <= t_reg;
                have_prev_reg  <= 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg    <= 1'b1;
                m_peak_reg     <= peak_reg;
                peak_reg       <= '0;
                prev_angle_reg <= '0;
                prev_time_reg  <= '0;
                have_prev_reg  <= 1'b0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_peak_rate = m_peak_reg;

    // Status back to the controller
    always_comb begin
        sts.cordic_done = special_reg || (step_reg == STEP_CNT_W'(STEPS));
        sts.div_done    = (div_cnt_reg == STEP_CNT_W'(DIVN_W));
        sts.need_div    = have_prev_reg && (t_reg > prev_time_reg);
        sts.last        = last_reg;
        sts.out_busy    = m_valid_reg && !m_ready;
    end

endmodule

`default_nettype wire

### rtl/peak_angular_velocity_tracker.sv
// Top level of the peak angular velocity tracker.
// Depends on pavt_pkg, pavt_ctrl and pavt_dp.
//
// Each point is accepted, then runs the iterative CORDIC rotator for
// CORDIC_STEPS micro-rotations, at most MAX_STEPS (none when y is zero),
// then angle clamp and wrap, then the 18-bit restoring divider when a rate
// is due, and then the update. The point marked last also loads the output
// word, waiting while that register still holds an untaken result. s_ready
// is high only between points.
`default_nettype none

module peak_angular_velocity_tracker #(
    parameter int CORDIC_STEPS = pavt_pkg::DEF_CORDIC_STEPS,
    parameter int COORD_BITS   = pavt_pkg::DEF_COORD_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  signed [pavt_pkg::IN_W-1:0] s_x_coord,
    input  wire  signed [pavt_pkg::IN_W-1:0] s_y_coord,
    input  wire  [pavt_pkg::TIME_W-1:0]      s_time_stamp,
    input  wire                              s_last_point,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [pavt_pkg::RATE_W-1:0]      m_peak_rate
);
    import pavt_pkg::*;

    pavt_cmd_t cmd;
    pavt_sts_t sts;

    pavt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pavt_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_x_coord    (s_x_coord),
        .s_y_coord    (s_y_coord),
        .s_time_stamp (s_time_stamp),
        .s_last_point (s_last_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_peak_rate  (m_peak_rate),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

### rtl/pavt_checker.sv
// Port-level checks for the peak angular velocity tracker, bound to the top.
// Depends on pavt_pkg for widths.
`default_nettype none

module pavt_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_valid,
    input wire                         s_ready,
    input wire                         m_valid,
    input wire                         m_ready,
    input wire [pavt_pkg::RATE_W-1:0]  m_peak_rate
);

    // Reset leaves no word pending and the input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("state after reset wrong");

    // One point at a time
    a_one_point: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input open right after accept");

    // A new result word comes only out of a busy cycle
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a point in work");

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_peak_rate)))
        else $error("stalled result changed");

endmodule

bind peak_angular_velocity_tracker pavt_checker u_pavt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_peak_rate (m_peak_rate)
);

`default_nettype wire
